[hw/rtl/per_id_match_confirm_cooldown_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the per-identity match confirm and cooldown block.
// ---------------------------------------------------------------------------
`ifndef PER_ID_MATCH_CONFIRM_COOLDOWN_MACROS_SVH
`define PER_ID_MATCH_CONFIRM_COOLDOWN_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define PIMCC_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |-> (cond)) else $error(msg);

// The condition must hold in the cycle after the trigger.
`define PIMCC_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cond)) else $error(msg);

`endif

[hw/rtl/pimcc_pkg.sv]
// ---------------------------------------------------------------------------
// pimcc_pkg
// Shared types and constants of the per-identity match confirm block.
// ---------------------------------------------------------------------------
package pimcc_pkg;

    // Field widths of one event and of one result.
    localparam int ID_W    = 6;
    localparam int CONF_W  = 16;
    localparam int TIME_W  = 32;
    localparam int HITS_W  = 8;
    localparam int MASK_W  = 64;
    localparam int GAP_W   = 16;

    // Packed stream widths, padded to whole bytes.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 16;

    // Default number of table entries.
    localparam int ID_COUNT_DEF = 64;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_GATE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ABSENT_SEC    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN_SEC  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ENROLLED_MASK = 3'd4;
    localparam int CFG_DATA_W = 64;

    // Configuration reset values.
    localparam logic [CONF_W-1:0] RST_SCORE_GATE    = 16'd32768;
    localparam logic [HITS_W-1:0] RST_CONFIRM_COUNT = 8'd3;
    localparam logic [GAP_W-1:0]  RST_ABSENT_SEC    = 16'd5;
    localparam logic [GAP_W-1:0]  RST_COOLDOWN_SEC  = 16'd60;
    localparam logic [MASK_W-1:0] RST_ENROLLED_MASK = 64'd0;

    // Saturation limit of the hit counter.
    localparam logic [HITS_W-1:0] HITS_MAX = 8'hFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;  // take the event and read the table
        logic commit;   // write back and load the result register
    } t_cmd;

endpackage

[hw/rtl/pimcc_ctrl.sv]
// ---------------------------------------------------------------------------
// pimcc_ctrl
// Controller: sequences the table read and write-back and owns the
// handshake state of both stream sides.
// ---------------------------------------------------------------------------
module pimcc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    output pimcc_pkg::t_cmd o_cmd
);
    import pimcc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_CALC = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // Commands: capture on an input transaction, commit once the result
    // register is free or being emptied this cycle.
    always_comb begin
        o_cmd.capture = (r_state == ST_IDLE) && i_s_tvalid;
        o_cmd.commit  = (r_state == ST_CALC) && (!r_out_valid || i_m_tready);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                if (o_cmd.commit) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Result register occupancy.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_out_valid;

endmodule

[hw/rtl/pimcc_datapath.sv]
// ---------------------------------------------------------------------------
// pimcc_datapath
// Datapath: configuration registers, per-identity table memories, valid
// bits, the entry and greeting decision and the result register.
// ---------------------------------------------------------------------------
module pimcc_datapath #(
    parameter int ID_COUNT = pimcc_pkg::ID_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pimcc_pkg::t_cmd                     i_cmd,
    input  logic [pimcc_pkg::S_TDATA_W-1:0]     i_s_tdata,
    input  logic                                i_cfg_we,
    input  logic [pimcc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pimcc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic [pimcc_pkg::M_TDATA_W-1:0]     o_m_tdata
);
    import pimcc_pkg::*;

    localparam int AW = $clog2(ID_COUNT);
    localparam logic [ID_W:0] ID_LIMIT = ID_COUNT[ID_W:0];

    // Configuration registers.
    logic [CONF_W-1:0] r_score_gate;
    logic [HITS_W-1:0] r_confirm;
    logic [GAP_W-1:0]  r_absent;
    logic [GAP_W-1:0]  r_cooldown;
    logic [MASK_W-1:0] r_enrolled;

    // Captured event.
    logic [ID_W-1:0]   r_ident;
    logic [CONF_W-1:0] r_conf;
    logic [TIME_W-1:0] r_now;

    // Table memories and their registered read data.
    logic [TIME_W-1:0] r_seen_mem  [ID_COUNT];
    logic [HITS_W-1:0] r_hit_mem   [ID_COUNT];
    logic [TIME_W-1:0] r_greet_mem [ID_COUNT];
    logic [TIME_W-1:0] r_seen_rd;
    logic [HITS_W-1:0] r_hit_rd;
    logic [TIME_W-1:0] r_greet_rd;

    // Per-entry valid bits.
    logic [ID_COUNT-1:0] r_seen_valid;
    logic [ID_COUNT-1:0] r_greet_valid;

    // Result register.
    logic [M_TDATA_W-1:0] r_out;

    logic [ID_W-1:0]   in_ident;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              in_range;
    logic              accept;
    logic              seen_v;
    logic              greet_v;
    logic [TIME_W-1:0] age_seen;
    logic [TIME_W-1:0] age_greet;
    logic              entered;
    logic [HITS_W-1:0] hits_next;
    logic              greet;
    logic [M_TDATA_W-1:0] n_out;

    assign in_ident = i_s_tdata[ID_W-1:0];
    assign rd_addr  = in_ident[AW-1:0];
    assign wr_addr  = r_ident[AW-1:0];

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_score_gate <= RST_SCORE_GATE;
            r_confirm    <= RST_CONFIRM_COUNT;
            r_absent     <= RST_ABSENT_SEC;
            r_cooldown   <= RST_COOLDOWN_SEC;
            r_enrolled   <= RST_ENROLLED_MASK;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SCORE_GATE:    r_score_gate <= i_cfg_data[CONF_W-1:0];
                CFG_CONFIRM_COUNT: r_confirm    <= i_cfg_data[HITS_W-1:0];
                CFG_ABSENT_SEC:    r_absent     <= i_cfg_data[GAP_W-1:0];
                CFG_COOLDOWN_SEC:  r_cooldown   <= i_cfg_data[GAP_W-1:0];
                CFG_ENROLLED_MASK: r_enrolled   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Event capture and table read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ident    <= in_ident;
            r_conf     <= i_s_tdata[ID_W +: CONF_W];
            r_now      <= i_s_tdata[ID_W+CONF_W +: TIME_W];
            r_seen_rd  <= r_seen_mem[rd_addr];
            r_hit_rd   <= r_hit_mem[rd_addr];
            r_greet_rd <= r_greet_mem[rd_addr];
        end
    end

    // Decision on the captured event.
    always_comb begin
        in_range  = ({1'b0, r_ident} < ID_LIMIT);
        accept    = in_range && (r_conf >= r_score_gate);
        seen_v    = in_range && r_seen_valid[wr_addr];
        greet_v   = in_range && r_greet_valid[wr_addr];
        age_seen  = r_now - r_seen_rd;
        age_greet = r_now - r_greet_rd;
        entered   = !seen_v || (age_seen >= {{(TIME_W-GAP_W){1'b0}}, r_absent});
        if (entered) begin
            hits_next = {{(HITS_W-1){1'b0}}, 1'b1};
        end else if (r_hit_rd == HITS_MAX) begin
            hits_next = HITS_MAX;
        end else begin
            hits_next = r_hit_rd + {{(HITS_W-1){1'b0}}, 1'b1};
        end
        greet = accept && (hits_next == r_confirm) && r_enrolled[r_ident]
                && (!greet_v
                    || (age_greet >= {{(TIME_W-GAP_W){1'b0}}, r_cooldown}));
        n_out = '0;
        if (accept) begin
            n_out[0]          = 1'b1;
            n_out[1]          = entered;
            n_out[2 +: HITS_W] = hits_next;
            n_out[2+HITS_W]   = greet;
        end
    end

    // Table write-back.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && accept) begin
            r_seen_mem[wr_addr] <= r_now;
            r_hit_mem[wr_addr]  <= hits_next;
            if (greet) begin
                r_greet_mem[wr_addr] <= r_now;
            end
        end
    end

    // Valid bits, cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_valid  <= '0;
            r_greet_valid <= '0;
        end else if (i_cmd.commit && accept) begin
            r_seen_valid[wr_addr] <= 1'b1;
            if (greet) begin
                r_greet_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_m_tdata = r_out;

endmodule

[hw/rtl/per_id_match_confirm_cooldown.sv]
// ---------------------------------------------------------------------------
// per_id_match_confirm_cooldown
// Per-identity hit confirmation with re-entry and greeting cooldown.
// ---------------------------------------------------------------------------
// Usage:
//   One recognition event enters on the slave stream (ident, confidence,
//   now_seconds). Each transaction yields exactly one result on the master
//   stream (accepted, entered, hits, greet).
//   An event is handled in order: the transaction edge reads the identity's
//   table entry into registered read data, and the commit then writes the
//   entry back and loads the result register. The input is not ready
//   again until that event has been written back and its result loaded.
//   If the receiver stalls, the result register holds its value; one more
//   event is still taken, and it waits for write-back until the result
//   register frees, so the input stays not ready meanwhile.
//   Reset restores all configuration registers and clears the seen and
//   greeted flags at once; no clearing pass is needed.
//   The configuration channel is always ready and must be written only
//   while no event is in flight.
// ---------------------------------------------------------------------------
module per_id_match_confirm_cooldown #(
    parameter int ID_COUNT = pimcc_pkg::ID_COUNT_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Fields from bit 0 up: ident[5:0], confidence[21:6], now_seconds[53:22].
    input  logic [pimcc_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // Fields from bit 0 up: accepted[0], entered[1], hits[9:2], greet[10].
    output logic [pimcc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [pimcc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pimcc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import pimcc_pkg::*;

    t_cmd cmd;

    assign o_cfg_ready = 1'b1;

    pimcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (cmd)
    );

    pimcc_datapath #(
        .ID_COUNT (ID_COUNT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_s_tdata   (s_axis_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tdata   (m_axis_tdata)
    );

endmodule

[hw/rtl/pimcc_checker.sv]
// ---------------------------------------------------------------------------
// pimcc_checker
// Port-level checks of the per-identity match confirm block.
// ---------------------------------------------------------------------------
`include "per_id_match_confirm_cooldown_macros.svh"

module pimcc_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [pimcc_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready
);
    import pimcc_pkg::*;

    // A stalled result must hold.
    `PIMCC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

    // The input drops ready after each input transaction.
    `PIMCC_ASSERT_NEXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input ready right after a transaction")

    // A rejected event reports all fields zero, padding included.
    `PIMCC_ASSERT_SAME(a_reject_zero, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata == '0, "rejected result carries nonzero fields")

    // Accepted events always have a nonzero hit count and clean padding.
    `PIMCC_ASSERT_SAME(a_accept_hits, m_axis_tvalid && m_axis_tdata[0], (m_axis_tdata[9:2] != 8'd0) && (m_axis_tdata[15:11] == 5'd0), "accepted result with zero hits")

endmodule

bind per_id_match_confirm_cooldown pimcc_checker u_pimcc_checker (.*);
